[hdl/tli_pkg.sv]
// ----------------------------------------------------------------------------
// tli_pkg
// Shared types, constants and the default point table of the refractive index
// interpolator.
// ----------------------------------------------------------------------------
package tli_pkg;

    // Field widths
    localparam int WL_W   = 16;   // wavelength, 0.0001 um
    localparam int IDX_W  = 13;   // index parts, 0.001
    localparam int NUM_W  = 29;   // blend numerator, <= 8191 * 65535
    localparam int DIV_STEPS = IDX_W;  // one quotient bit per step

    // Table geometry
    localparam int DEFAULT_POINTS     = 37;
    localparam int MAX_POINTS         = 64;
    localparam int TABLE_POINTS_DEF   = 37;
    localparam int PT_ADDR_W          = 6;   // address wide enough for MAX_POINTS

    // One table entry: wavelength, real part, imaginary part (42 bits)
    typedef struct packed {
        logic [WL_W-1:0]  wl;
        logic [IDX_W-1:0] re;
        logic [IDX_W-1:0] im;
    } t_point;

    // Sequencer states
    typedef enum logic [2:0] {
        S_LOAD,
        S_IDLE,
        S_SCAN,
        S_MUL,
        S_SUM,
        S_DIV,
        S_DONE
    } t_state;

    // Default points, ascending in wavelength
    localparam t_point DEFAULT_TABLE [DEFAULT_POINTS] = '{
        '{16'd1240,  13'd930,  13'd860}, '{16'd1350,  13'd925,  13'd1000},
        '{16'd1378,  13'd920,  13'd1140}, '{16'd1459,  13'd920,  13'd1200},
        '{16'd1550,  13'd920,  13'd1400}, '{16'd1653,  13'd960,  13'd1600},
        '{16'd1771,  13'd1000, 13'd1800}, '{16'd1907,  13'd1100, 13'd2050},
        '{16'd2066,  13'd1300, 13'd2340}, '{16'd2254,  13'd1380, 13'd2842},
        '{16'd2480,  13'd1394, 13'd3197}, '{16'd2755,  13'd1953, 13'd4297},
        '{16'd3100,  13'd3905, 13'd3336}, '{16'd3306,  13'd3947, 13'd2922},
        '{16'd3542,  13'd4020, 13'd2667}, '{16'd3815,  13'd4144, 13'd2405},
        '{16'd4133,  13'd4082, 13'd2145}, '{16'd4275,  13'd4037, 13'd2140},
        '{16'd4428,  13'd4035, 13'd2181}, '{16'd4592,  13'd4082, 13'd2240},
        '{16'd4769,  13'd4180, 13'd2309}, '{16'd4959,  13'd4340, 13'd2384},
        '{16'd5166,  13'd4610, 13'd2455}, '{16'd5391,  13'd5062, 13'd2318},
        '{16'd5636,  13'd5283, 13'd2049}, '{16'd5904,  13'd5748, 13'd1634},
        '{16'd6199,  13'd5588, 13'd933},  '{16'd6526,  13'd5380, 13'd638},
        '{16'd6888,  13'd5067, 13'd500},  '{16'd7293,  13'd4897, 13'd401},
        '{16'd7749,  13'd4763, 13'd345},  '{16'd8266,  13'd4653, 13'd298},
        '{16'd12400, 13'd4325, 13'd81},   '{16'd13780, 13'd4285, 13'd75},
        '{16'd15500, 13'd4275, 13'd57},   '{16'd17710, 13'd4180, 13'd28},
        '{16'd20000, 13'd4180, 13'd0}
    };

    // Entry loaded at a given address; entries past the defaults repeat the last
    function automatic t_point default_point(input logic [PT_ADDR_W-1:0] addr);
        t_point pt;
        if (int'(addr) < DEFAULT_POINTS) begin
            pt = DEFAULT_TABLE[addr];
        end else begin
            pt = DEFAULT_TABLE[DEFAULT_POINTS-1];
        end
        return pt;
    endfunction

endpackage

[hdl/tli_mem.sv]
// ----------------------------------------------------------------------------
// tli_mem
// Point table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tli_mem #(
    parameter int DEPTH = tli_pkg::TABLE_POINTS_DEF,
    parameter int AW    = tli_pkg::PT_ADDR_W
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  tli_pkg::t_point  i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output tli_pkg::t_point  o_rd_data
);

    tli_pkg::t_point r_mem [DEPTH];
    tli_pkg::t_point r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/tli_div.sv]
// ----------------------------------------------------------------------------
// tli_div
// Two-lane restoring divider sharing one divisor; one quotient bit per cycle
// per lane. The quotient is known to fit in IDX_W bits.
// ----------------------------------------------------------------------------
module tli_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [tli_pkg::NUM_W-1:0]    i_num_re,
    input  logic [tli_pkg::NUM_W-1:0]    i_num_im,
    input  logic [tli_pkg::WL_W-1:0]     i_den,
    output logic                         o_done,
    output logic [tli_pkg::IDX_W-1:0]    o_quot_re,
    output logic [tli_pkg::IDX_W-1:0]    o_quot_im
);

    localparam int NW = tli_pkg::NUM_W;
    localparam int QW = tli_pkg::IDX_W;
    localparam int SW = $clog2(tli_pkg::DIV_STEPS);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [SW-1:0] r_step, n_step;
    logic [NW-1:0] r_rem_re, n_rem_re;
    logic [NW-1:0] r_rem_im, n_rem_im;
    logic [NW-1:0] r_dsh, n_dsh;
    logic [QW-1:0] r_q_re, n_q_re;
    logic [QW-1:0] r_q_im, n_q_im;
    logic          ge_re, ge_im;

    // Trial subtract of the shifted divisor in both lanes
    always_comb begin
        ge_re    = (r_rem_re >= r_dsh);
        ge_im    = (r_rem_im >= r_dsh);
        n_busy   = r_busy;
        n_done   = 1'b0;
        n_step   = r_step;
        n_rem_re = r_rem_re;
        n_rem_im = r_rem_im;
        n_dsh    = r_dsh;
        n_q_re   = r_q_re;
        n_q_im   = r_q_im;
        if (i_start) begin
            n_busy   = 1'b1;
            n_step   = SW'(tli_pkg::DIV_STEPS - 1);
            n_rem_re = i_num_re;
            n_rem_im = i_num_im;
            n_dsh    = NW'({i_den, {(QW-1){1'b0}}});
            n_q_re   = '0;
            n_q_im   = '0;
        end else if (r_busy) begin
            if (ge_re) begin
                n_rem_re = r_rem_re - r_dsh;
            end
            if (ge_im) begin
                n_rem_im = r_rem_im - r_dsh;
            end
            n_q_re = {r_q_re[QW-2:0], ge_re};
            n_q_im = {r_q_im[QW-2:0], ge_im};
            n_dsh  = r_dsh >> 1;
            if (r_step == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_step = r_step - 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_rem_re <= n_rem_re;
        r_rem_im <= n_rem_im;
        r_dsh    <= n_dsh;
        r_q_re   <= n_q_re;
        r_q_im   <= n_q_im;
    end

    assign o_done    = r_done;
    assign o_quot_re = r_q_re;
    assign o_quot_im = r_q_im;

`ifndef SYNTHESIS
    // A new division never starts on top of a running one
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");

    // Done is a single-cycle pulse that ends the busy period
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> $past(r_busy) && !r_busy)
        else $error("divider done without a finished run");

    // Quotient is only presented once the iteration has stopped
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while still iterating");
`endif

endmodule

[hdl/table_linear_interpolator.sv]
// ----------------------------------------------------------------------------
// table_linear_interpolator
// Complex refractive index lookup by linear interpolation in a point table.
// ----------------------------------------------------------------------------
// After reset the block loads TABLE_POINTS entries (the count is held between
// 2 and 64) of the default point table into its memory and takes no
// transaction meanwhile. A query then walks the table one entry a cycle
// through the memory's single read port until it finds the enclosing segment,
// forms both blend numerators in a multiply and an add state, and divides
// them in a shared 13-step serial divider. A wavelength below the first point
// is settled at the first entry and one above the last point once the whole
// table has been walked, both as the clamped value of that end point; an
// interpolated one goes on from the segment's right end through the multiply,
// add and divide steps. One query is in work at a time; the result register
// lets the next query enter while a result waits.
// ----------------------------------------------------------------------------
module table_linear_interpolator #(
    parameter int TABLE_POINTS = tli_pkg::TABLE_POINTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [tli_pkg::WL_W-1:0]     i_wavelength,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [tli_pkg::IDX_W-1:0]    o_index_real,
    output logic [tli_pkg::IDX_W-1:0]    o_index_imag,
    output logic                         o_clamped
);

    // point count held between 2 and the largest table
    localparam int USED_POINTS = (TABLE_POINTS < 2) ? 2 :
                                 ((TABLE_POINTS > tli_pkg::MAX_POINTS) ?
                                  tli_pkg::MAX_POINTS : TABLE_POINTS);
    localparam int AW = $clog2(USED_POINTS);
    localparam logic [AW-1:0] LAST = AW'(USED_POINTS - 1);
    localparam int WW = tli_pkg::WL_W;
    localparam int IW = tli_pkg::IDX_W;
    localparam int NW = tli_pkg::NUM_W;

    tli_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_idx, n_idx;
    logic [WW-1:0]   r_wl, n_wl;
    tli_pkg::t_point r_prev, n_prev;
    tli_pkg::t_point r_q, n_q;
    logic [WW-1:0]   r_d1, n_d1;
    logic [WW-1:0]   r_d2, n_d2;
    logic [WW-1:0]   r_den, n_den;
    logic [NW-1:0]   r_pra, n_pra, r_prb, n_prb;
    logic [NW-1:0]   r_pia, n_pia, r_pib, n_pib;
    logic [IW-1:0]   r_res_re, n_res_re;
    logic [IW-1:0]   r_res_im, n_res_im;
    logic            r_res_cl, n_res_cl;
    logic            r_out_valid, n_out_valid;
    logic [IW-1:0]   r_out_re, n_out_re;
    logic [IW-1:0]   r_out_im, n_out_im;
    logic            r_out_cl, n_out_cl;

    logic              mem_wr_en;
    logic [AW-1:0]     mem_rd_addr;
    tli_pkg::t_point   mem_wr_data;
    tli_pkg::t_point   mem_rd_data;
    logic              div_start;
    logic              div_done;
    logic [IW-1:0]     div_q_re, div_q_im;
    logic [WW:0]       seg_len;
    logic              in_accept;
    logic              out_accept;

    assign in_accept  = i_in_valid && o_in_ready;
    assign out_accept = r_out_valid && i_out_ready;
    assign seg_len    = {1'b0, r_d1} + {1'b0, r_d2};

    // Point table memory
    tli_mem #(
        .DEPTH (USED_POINTS),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (r_idx),
        .i_wr_data (mem_wr_data),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    // Shared serial divider for both index parts
    tli_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_num_re  (NW'(r_pra + r_prb)),
        .i_num_im  (NW'(r_pia + r_pib)),
        .i_den     (r_den),
        .o_done    (div_done),
        .o_quot_re (div_q_re),
        .o_quot_im (div_q_im)
    );

    // Sequencer: table load, segment scan, blend, result hand-off
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_wl        = r_wl;
        n_prev      = r_prev;
        n_q         = r_q;
        n_d1        = r_d1;
        n_d2        = r_d2;
        n_den       = r_den;
        n_pra       = r_pra;
        n_prb       = r_prb;
        n_pia       = r_pia;
        n_pib       = r_pib;
        n_res_re    = r_res_re;
        n_res_im    = r_res_im;
        n_res_cl    = r_res_cl;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_re    = r_out_re;
        n_out_im    = r_out_im;
        n_out_cl    = r_out_cl;
        o_in_ready  = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_data = tli_pkg::default_point(tli_pkg::PT_ADDR_W'(r_idx));
        mem_rd_addr = (r_idx == LAST) ? r_idx : r_idx + 1'b1;
        div_start   = 1'b0;

        unique case (r_state)
            tli_pkg::S_LOAD: begin
                mem_wr_en = 1'b1;
                if (r_idx == LAST) begin
                    n_state = tli_pkg::S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            tli_pkg::S_IDLE: begin
                o_in_ready  = 1'b1;
                mem_rd_addr = '0;
                if (i_in_valid) begin
                    n_wl    = i_wavelength;
                    n_idx   = '0;
                    n_state = tli_pkg::S_SCAN;
                end
            end
            tli_pkg::S_SCAN: begin
                // mem_rd_data holds entry r_idx
                if (r_idx == '0) begin
                    if (r_wl < mem_rd_data.wl) begin
                        n_res_re = mem_rd_data.re;
                        n_res_im = mem_rd_data.im;
                        n_res_cl = 1'b1;
                        n_state  = tli_pkg::S_DONE;
                    end else begin
                        n_prev = mem_rd_data;
                        n_idx  = r_idx + 1'b1;
                    end
                end else if (r_wl <= mem_rd_data.wl) begin
                    // earlier entries all lie below, so this segment encloses
                    n_q     = mem_rd_data;
                    n_d1    = r_wl - r_prev.wl;
                    n_d2    = mem_rd_data.wl - r_wl;
                    n_state = tli_pkg::S_MUL;
                end else if (r_idx == LAST) begin
                    n_res_re = mem_rd_data.re;
                    n_res_im = mem_rd_data.im;
                    n_res_cl = 1'b1;
                    n_state  = tli_pkg::S_DONE;
                end else begin
                    n_prev = mem_rd_data;
                    n_idx  = r_idx + 1'b1;
                end
            end
            tli_pkg::S_MUL: begin
                n_res_cl = 1'b0;
                if (seg_len == '0) begin
                    // zero-length segment: left point as is
                    n_res_re = r_prev.re;
                    n_res_im = r_prev.im;
                    n_state  = tli_pkg::S_DONE;
                end else begin
                    n_den   = seg_len[WW-1:0];
                    n_pra   = r_prev.re * r_d2;
                    n_prb   = r_q.re * r_d1;
                    n_pia   = r_prev.im * r_d2;
                    n_pib   = r_q.im * r_d1;
                    n_state = tli_pkg::S_SUM;
                end
            end
            tli_pkg::S_SUM: begin
                div_start = 1'b1;
                n_state   = tli_pkg::S_DIV;
            end
            tli_pkg::S_DIV: begin
                if (div_done) begin
                    n_res_re = div_q_re;
                    n_res_im = div_q_im;
                    n_state  = tli_pkg::S_DONE;
                end
            end
            tli_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_re    = r_res_re;
                    n_out_im    = r_res_im;
                    n_out_cl    = r_res_cl;
                    n_state     = tli_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tli_pkg::S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tli_pkg::S_LOAD;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_wl     <= n_wl;
        r_prev   <= n_prev;
        r_q      <= n_q;
        r_d1     <= n_d1;
        r_d2     <= n_d2;
        r_den    <= n_den;
        r_pra    <= n_pra;
        r_prb    <= n_prb;
        r_pia    <= n_pia;
        r_pib    <= n_pib;
        r_res_re <= n_res_re;
        r_res_im <= n_res_im;
        r_res_cl <= n_res_cl;
        r_out_re <= n_out_re;
        r_out_im <= n_out_im;
        r_out_cl <= n_out_cl;
    end

    assign o_out_valid  = r_out_valid;
    assign o_index_real = r_out_re;
    assign o_index_imag = r_out_im;
    assign o_clamped    = r_out_cl;

`ifndef SYNTHESIS
    // No query is taken while the table is still being loaded
    a_no_accept_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tli_pkg::S_LOAD) |-> !o_in_ready)
        else $error("transaction accepted during table load");

    // Divider completion only arrives while the sequencer waits for it
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == tli_pkg::S_DIV))
        else $error("divider done outside divide state");

    // The scan starts at the first table entry after an accepted query
    a_scan_from_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == tli_pkg::S_SCAN) && (r_idx == '0))
        else $error("scan did not start at entry zero");

    // A finished result is never dropped onto an occupied output register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tli_pkg::S_DONE && r_out_valid && !out_accept)
            |=> (r_state == tli_pkg::S_DONE))
        else $error("result left done state while output was full");
`endif

endmodule
